// ----- src/kbl_pkg.sv -----
`timescale 1ns / 1ps

package kbl_pkg;

  localparam int MAX_BLOCK_DEF = 64;
  localparam int LIM_W = 9;
  localparam int QDEPTH = 2;
  localparam int CFG_W = 12;

  localparam logic [6:0] MAX_LEN_RST = 7'd64;
  localparam logic [11:0] FIRST_TO_RST = 12'd2000;
  localparam logic [11:0] BYTE_TO_RST = 12'd1000;
  localparam logic [7:0] BYTE_MASK = 8'hFF;

  typedef enum logic [1:0] {
    CFG_MAX_LEN = 2'd0,
    CFG_FIRST_TO = 2'd1,
    CFG_BYTE_TO = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    MODE_START_LEN = 3'd0,
    MODE_START_FIX = 3'd1,
    MODE_LINE = 3'd2,
    MODE_SEND = 3'd3,
    MODE_TICK = 3'd4,
    MODE_OPEN = 3'd5,
    MODE_CLOSE = 3'd6,
    MODE_BAD = 3'd7
  } mode_t;

  typedef enum logic [2:0] {
    OP_START_LEN,
    OP_START_FIX,
    OP_LINE,
    OP_SEND,
    OP_TICK,
    OP_OPEN,
    OP_CLOSE,
    OP_BAD
  } op_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0,
    ST_DONE = 3'd1,
    ST_ECHO = 3'd2,
    ST_CNT = 3'd3,
    ST_LONG = 3'd4,
    ST_TIMEOUT = 3'd5,
    ST_IGN = 3'd6
  } status_t;

  typedef struct packed {
    op_t op;
    logic [7:0] data;
    logic last;
  } cmd_t;

  typedef struct packed {
    logic tx_valid;
    logic [7:0] tx_byte;
    logic rx_valid;
    logic [7:0] rx_byte;
    logic [5:0] rx_index;
    logic rx_last;
    status_t status;
    logic [7:0] counter_now;
    logic link_up;
    logic [7:0] data_error_count;
    logic [7:0] timeout_error_count;
  } result_t;

endpackage

// ----- src/kbl_if.sv -----
`timescale 1ns / 1ps

interface kbl_req_if;
  logic valid;
  logic ready;
  logic [2:0] mode;
  logic [7:0] data;
  logic last;

  modport source (output valid, mode, data, last, input ready);
  modport sink (input valid, mode, data, last, output ready);
endinterface

interface kbl_rsp_if;
  logic valid;
  logic ready;
  logic tx_valid;
  logic [7:0] tx_byte;
  logic rx_valid;
  logic [7:0] rx_byte;
  logic [5:0] rx_index;
  logic rx_last;
  logic [2:0] status;
  logic [7:0] counter_now;
  logic link_up;
  logic [7:0] data_error_count;
  logic [7:0] timeout_error_count;

  modport source (output valid, tx_valid, tx_byte, rx_valid, rx_byte, rx_index, rx_last,
                  status, counter_now, link_up, data_error_count, timeout_error_count,
                  input ready);
  modport sink (input valid, tx_valid, tx_byte, rx_valid, rx_byte, rx_index, rx_last,
                status, counter_now, link_up, data_error_count, timeout_error_count,
                output ready);
endinterface

// ----- src/kw1281_block_link_engine.sv -----
`timescale 1ns / 1ps

// Channel  Dir  Handshake          Payload
// req      in   req.valid/ready    mode, data, last
// rsp      out  rsp.valid/ready    tx, rx, status, counter and error fields
// cfg      in   cfg_we             cfg_index, cfg_data
//
// Execute sustains one item per cycle while rsp.ready stays high.
// From accept to result an item passes through a queue entry, then the result register.
// A two-entry queue separates intake from execute; req.ready drops only when it fills.
// Execute stalls only while the result register holds an untaken result.
// Synchronous reset clears link state, counters and configuration to defaults.

module kw1281_block_link_engine #(
  parameter int MAX_BLOCK = kbl_pkg::MAX_BLOCK_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [kbl_pkg::CFG_W-1:0] cfg_data,
  kbl_req_if.sink req,
  kbl_rsp_if.source rsp
);

  kbl_pkg::cmd_t in_cmd;
  kbl_pkg::cmd_t head;
  kbl_pkg::result_t out_q;
  logic q_full;
  logic q_empty;
  logic pop;
  logic out_valid;

  assign req.ready = !q_full;

  kbl_front u_front (
    .mode (req.mode),
    .data (req.data),
    .last (req.last),
    .cmd  (in_cmd)
  );

  kbl_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (req.valid && !q_full),
    .push_cmd (in_cmd),
    .full     (q_full),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty)
  );

  kbl_back #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .head       (head),
    .head_valid (!q_empty),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (rsp.ready),
    .out_q      (out_q)
  );

  assign rsp.valid = out_valid;
  assign rsp.tx_valid = out_q.tx_valid;
  assign rsp.tx_byte = out_q.tx_byte;
  assign rsp.rx_valid = out_q.rx_valid;
  assign rsp.rx_byte = out_q.rx_byte;
  assign rsp.rx_index = out_q.rx_index;
  assign rsp.rx_last = out_q.rx_last;
  assign rsp.status = out_q.status;
  assign rsp.counter_now = out_q.counter_now;
  assign rsp.link_up = out_q.link_up;
  assign rsp.data_error_count = out_q.data_error_count;
  assign rsp.timeout_error_count = out_q.timeout_error_count;

endmodule

// ----- src/kbl_front.sv -----
`timescale 1ns / 1ps

module kbl_front (
  input  logic [2:0] mode,
  input  logic [7:0] data,
  input  logic last,
  output kbl_pkg::cmd_t cmd
);

  kbl_pkg::op_t op;

  always_comb begin
    case (kbl_pkg::mode_t'(mode))
      kbl_pkg::MODE_START_LEN: op = kbl_pkg::OP_START_LEN;
      // fixed receive of length zero falls back to length-prefixed
      kbl_pkg::MODE_START_FIX: op = (data == 8'd0) ? kbl_pkg::OP_START_LEN
                                                   : kbl_pkg::OP_START_FIX;
      kbl_pkg::MODE_LINE: op = kbl_pkg::OP_LINE;
      kbl_pkg::MODE_SEND: op = kbl_pkg::OP_SEND;
      kbl_pkg::MODE_TICK: op = kbl_pkg::OP_TICK;
      kbl_pkg::MODE_OPEN: op = kbl_pkg::OP_OPEN;
      kbl_pkg::MODE_CLOSE: op = kbl_pkg::OP_CLOSE;
      default: op = kbl_pkg::OP_BAD;
    endcase
  end

  assign cmd = '{op: op, data: data, last: last};

endmodule

// ----- src/kbl_queue.sv -----
`timescale 1ns / 1ps

module kbl_queue (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  kbl_pkg::cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output kbl_pkg::cmd_t head,
  output logic empty
);

  localparam int AW = (kbl_pkg::QDEPTH > 1) ? $clog2(kbl_pkg::QDEPTH) : 1;
  localparam logic [AW:0] DEPTH = (AW + 1)'(kbl_pkg::QDEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(kbl_pkg::QDEPTH - 1);

  kbl_pkg::cmd_t mem [kbl_pkg::QDEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0] count;

  assign full = (count == DEPTH);
  assign empty = (count == '0);
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) empty |-> !pop)
    else $error("queue read while empty");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count lost a push");
`endif

endmodule

// ----- src/kbl_back.sv -----
`timescale 1ns / 1ps

module kbl_back #(
  parameter int MAX_BLOCK = kbl_pkg::MAX_BLOCK_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [kbl_pkg::CFG_W-1:0] cfg_data,
  input  kbl_pkg::cmd_t head,
  input  logic head_valid,
  output logic pop,
  output logic out_valid,
  input  logic out_ready,
  output kbl_pkg::result_t out_q
);

  localparam logic [kbl_pkg::LIM_W-1:0] MAX_LIM = kbl_pkg::LIM_W'(MAX_BLOCK);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_RX,
    PH_ECHO,
    PH_TXNEXT
  } phase_t;

  phase_t phase, phase_next;
  logic [6:0] expected_len, expected_len_next;
  logic [6:0] received_count, received_count_next;
  logic ack_every_byte, ack_every_byte_next;
  logic [7:0] sent_byte, sent_byte_next;
  logic [7:0] block_counter, block_counter_next;
  logic connected, connected_next;
  logic [11:0] timer, timer_next;
  logic [7:0] data_errors, data_errors_next;
  logic [7:0] timeout_errors, timeout_errors_next;
  logic [6:0] max_block_len;
  logic [11:0] first_to;
  logic [11:0] byte_to;

  logic [kbl_pkg::LIM_W-1:0] limit;
  logic [kbl_pkg::LIM_W-1:0] data_p1;
  logic [7:0] cnt;
  logic [6:0] exp_eff;
  logic fail;
  kbl_pkg::result_t res;

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    return (v == 8'hFF) ? v : v + 8'd1;
  endfunction

  assign pop = head_valid && (!out_valid || out_ready);
  assign limit = ({2'b00, max_block_len} < MAX_LIM) ? {2'b00, max_block_len} : MAX_LIM;
  assign data_p1 = {1'b0, head.data} + 9'd1;
  assign cnt = {1'b0, received_count} + 8'd1;

  always_comb begin
    phase_next = phase;
    expected_len_next = expected_len;
    received_count_next = received_count;
    ack_every_byte_next = ack_every_byte;
    sent_byte_next = sent_byte;
    block_counter_next = block_counter;
    connected_next = connected;
    timer_next = timer;
    data_errors_next = data_errors;
    timeout_errors_next = timeout_errors;
    exp_eff = expected_len;
    fail = 1'b0;
    res = '0;
    res.status = kbl_pkg::ST_OK;

    case (head.op)
      kbl_pkg::OP_START_LEN: begin
        received_count_next = '0;
        timer_next = first_to;
        ack_every_byte_next = 1'b1;
        expected_len_next = '0;
        phase_next = PH_RX;
      end
      kbl_pkg::OP_START_FIX: begin
        received_count_next = '0;
        timer_next = first_to;
        if ({1'b0, head.data} > limit) begin
          res.status = kbl_pkg::ST_LONG;
          phase_next = PH_IDLE;
        end else begin
          ack_every_byte_next = 1'b0;
          expected_len_next = head.data[6:0];
          phase_next = PH_RX;
        end
      end
      kbl_pkg::OP_LINE: begin
        if (phase == PH_RX) begin
          if (ack_every_byte && cnt == 8'd1) begin
            if (data_p1 > limit) begin
              res.status = kbl_pkg::ST_LONG;
              phase_next = PH_IDLE;
              fail = 1'b1;
            end else begin
              exp_eff = data_p1[6:0];
              expected_len_next = data_p1[6:0];
            end
          end
          if (!fail && ack_every_byte && cnt == 8'd2 && head.data != block_counter) begin
            connected_next = 1'b0;
            data_errors_next = sat_inc(data_errors);
            res.status = kbl_pkg::ST_CNT;
            phase_next = PH_IDLE;
            fail = 1'b1;
          end
          if (!fail) begin
            received_count_next = cnt[6:0];
            res.rx_valid = 1'b1;
            res.rx_byte = head.data;
            res.rx_index = received_count[5:0];
            if ((ack_every_byte && cnt < {1'b0, exp_eff}) ||
                (!ack_every_byte && cnt == {1'b0, exp_eff})) begin
              res.tx_valid = 1'b1;
              res.tx_byte = head.data ^ kbl_pkg::BYTE_MASK;
            end
            if (cnt >= {1'b0, exp_eff}) begin
              res.rx_last = 1'b1;
              res.status = kbl_pkg::ST_DONE;
              block_counter_next = block_counter + 8'd1;
              phase_next = PH_IDLE;
            end else begin
              timer_next = byte_to;
            end
          end
        end else if (phase == PH_ECHO) begin
          if (head.data != (sent_byte ^ kbl_pkg::BYTE_MASK)) begin
            connected_next = 1'b0;
            data_errors_next = sat_inc(data_errors);
            res.status = kbl_pkg::ST_ECHO;
            phase_next = PH_IDLE;
          end else begin
            phase_next = PH_TXNEXT;
          end
        end else begin
          res.status = kbl_pkg::ST_IGN;
        end
      end
      kbl_pkg::OP_SEND: begin
        if (phase inside {PH_IDLE, PH_TXNEXT}) begin
          res.tx_valid = 1'b1;
          res.tx_byte = head.data;
          if (head.last) begin
            res.status = kbl_pkg::ST_DONE;
            block_counter_next = block_counter + 8'd1;
            phase_next = PH_IDLE;
          end else begin
            sent_byte_next = head.data;
            timer_next = byte_to;
            phase_next = PH_ECHO;
          end
        end else begin
          res.status = kbl_pkg::ST_IGN;
        end
      end
      kbl_pkg::OP_TICK: begin
        if (phase inside {PH_RX, PH_ECHO}) begin
          if (timer <= 12'd1) begin
            timer_next = '0;
            connected_next = 1'b0;
            timeout_errors_next = sat_inc(timeout_errors);
            res.status = kbl_pkg::ST_TIMEOUT;
            phase_next = PH_IDLE;
          end else begin
            timer_next = timer - 12'd1;
          end
        end
      end
      kbl_pkg::OP_OPEN: begin
        connected_next = 1'b1;
        block_counter_next = '0;
        phase_next = PH_IDLE;
      end
      kbl_pkg::OP_CLOSE: begin
        connected_next = 1'b0;
        phase_next = PH_IDLE;
      end
      default: begin
        res.status = kbl_pkg::ST_IGN;
      end
    endcase

    res.counter_now = block_counter_next;
    res.link_up = connected_next;
    res.data_error_count = data_errors_next;
    res.timeout_error_count = timeout_errors_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      expected_len <= '0;
      received_count <= '0;
      ack_every_byte <= 1'b0;
      sent_byte <= '0;
      block_counter <= '0;
      connected <= 1'b0;
      timer <= '0;
      data_errors <= '0;
      timeout_errors <= '0;
      max_block_len <= kbl_pkg::MAX_LEN_RST;
      first_to <= kbl_pkg::FIRST_TO_RST;
      byte_to <= kbl_pkg::BYTE_TO_RST;
      out_valid <= 1'b0;
      out_q <= '0;
    end else begin
      if (cfg_we) begin
        case (kbl_pkg::cfg_idx_t'(cfg_index))
          kbl_pkg::CFG_MAX_LEN: max_block_len <= cfg_data[6:0];
          kbl_pkg::CFG_FIRST_TO: first_to <= cfg_data;
          kbl_pkg::CFG_BYTE_TO: byte_to <= cfg_data;
          default: ;
        endcase
      end
      if (pop) begin
        phase <= phase_next;
        expected_len <= expected_len_next;
        received_count <= received_count_next;
        ack_every_byte <= ack_every_byte_next;
        sent_byte <= sent_byte_next;
        block_counter <= block_counter_next;
        connected <= connected_next;
        timer <= timer_next;
        data_errors <= data_errors_next;
        timeout_errors <= timeout_errors_next;
        out_valid <= 1'b1;
        out_q <= res;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_timeout_drops_link: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_q.status == kbl_pkg::ST_TIMEOUT) |-> !out_q.link_up)
    else $error("timeout result with link still up");
  a_last_is_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_q.rx_last) |-> (out_q.rx_valid && out_q.status == kbl_pkg::ST_DONE))
    else $error("block end without done status");
  a_rx_count_bound: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_RX && expected_len != '0) |-> received_count < expected_len)
    else $error("receive count ran past block length");
  a_errors_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (data_errors >= $past(data_errors) && timeout_errors >= $past(timeout_errors)))
    else $error("error count decreased");
`endif

endmodule
